// ----- hdl/bnp_pkg.sv -----
// shared types and constants for the padded bgra to nv12 converter
// no dependencies; every other file imports this package
package bnp_pkg;

  // fixed field widths
  localparam int DIM_W  = 14;  // padded dimension, covers 8192 + 63
  localparam int CFG_W  = 13;
  localparam int YA_W   = 24;
  localparam int UA_W   = 25;
  localparam int LEN_W  = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // result count limit per pixel
  localparam int MAX_RESULTS = 17;
  localparam int CNT_W       = 5;

  // front to back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // register indexes
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd1080;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FILL  = 1'b1;

  // fill colors
  localparam logic [7:0] Y_BLACK = 8'd16;
  localparam logic [7:0] UV_GRAY = 8'd128;

  // bt.601 studio range coefficients
  localparam logic signed [17:0] CY_R = 18'sd66;
  localparam logic signed [17:0] CY_G = 18'sd129;
  localparam logic signed [17:0] CY_B = 18'sd25;
  localparam logic signed [17:0] CU_R = -18'sd38;
  localparam logic signed [17:0] CU_G = -18'sd74;
  localparam logic signed [17:0] CU_B = 18'sd112;
  localparam logic signed [17:0] CV_R = 18'sd112;
  localparam logic signed [17:0] CV_G = -18'sd94;
  localparam logic signed [17:0] CV_B = -18'sd18;
  localparam logic signed [17:0] C_ROUND    = 18'sd128;
  localparam logic signed [17:0] C_Y_OFS    = 18'sd16;
  localparam logic signed [17:0] C_UV_BIAS  = 18'sd32768;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic             kind;
    logic [YA_W-1:0]  y_address;
    logic [7:0]       y_value;
    logic [LEN_W-1:0] y_length;
    logic             uv_write;
    logic [UA_W-1:0]  uv_address;
    logic [7:0]       u_value;
    logic [7:0]       v_value;
    logic [LEN_W-1:0] uv_length;
    logic             last;
  } res_t;

  // picture geometry derived from the registers
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic [DIM_W-1:0] fill_start;
    logic [DIM_W-1:0] fill_uv_len;
    logic             margin;
    logic [UA_W-1:0]  uvbase;
    logic [UA_W-1:0]  hpw;
    logic [UA_W-1:0]  hhpw;
  } dims_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [7:0]      y_value;
    logic [7:0]      u_value;
    logic [7:0]      v_value;
    logic            even;
    logic            row_odd;
    logic [YA_W-1:0] pix_y_addr;
    logic [UA_W-1:0] pix_uv_addr;
    logic [YA_W-1:0] fill_y_addr;
    logic [UA_W-1:0] fill_uv_addr;
    logic            row_end;
    logic            frame_end;
  } item_t;

endpackage

// ----- hdl/bgra_to_nv12_padded_converter_top.sv -----
// top level of the padded bgra to nv12 converter
// depends on bnp_pkg, bnp_cfg, bnp_front, bnp_queue, bnp_back
//
//  port group   direction  flow control           payload
//  in_*         input      in_valid_i/in_stall_o  pix_t (blue, green, red)
//  out_*        output     out_valid_o/out_stall_i res_t (one nv12 write)
//  apb          input      psel/penable/pready    src_width, src_height
//
// one pixel per cycle enters unless stalled; each passes stage one, stage two and
// the queue before the result register. the sequencer issues one result a cycle
// unless stalled: one per pixel, one more at a row end with a right margin, and up
// to MAX_RESULTS - 2 bottom fill rows after the last pixel of a frame. a four entry
// queue absorbs those bursts; in_stall_o rises only when it is full. rst_ni clears
// counters, queue and output register; registers return to 1920x1080.
module bgra_to_nv12_padded_converter_top import bnp_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int ALIGN_MASK = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_t              in_pix_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output res_t              out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  dims_t dims;
  item_t push_item, head_item;
  logic  push, pop, q_empty, q_full;

  // registers and geometry
  bnp_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ALIGN_MASK (ALIGN_MASK)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  // pixel intake and classification
  bnp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix_i),
    .dims_i     (dims),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // decoupling queue
  bnp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // result sequencer
  bnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .q_empty_i   (q_empty),
    .dims_i      (dims),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

// ----- hdl/bnp_cfg.sv -----
// register port and picture geometry for the converter
// depends on bnp_pkg
module bnp_cfg import bnp_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int ALIGN_MASK = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dims_t             dims_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] w, h, pw, ph, w_inc, start;
  logic [UA_W-1:0]  uvbase_q, hpw_q, hhpw_q;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_SRC_WIDTH;
      height_q <= RST_SRC_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[ADDR_W-1])
        REG_SRC_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_SRC_WIDTH:  prdata = DATA_W'(width_q);
      REG_SRC_HEIGHT: prdata = DATA_W'(height_q);
      default:        prdata = '0;
    endcase
  end

  // clamp to 1..max
  always_comb begin
    if (width_q == '0) begin
      w = DIM_W'(1);
    end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h = DIM_W'(1);
    end else if (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = DIM_W'(height_q);
    end
  end

  // padded size and right margin chroma run
  assign pw    = (w + DIM_W'(ALIGN_MASK)) & ~DIM_W'(ALIGN_MASK);
  assign ph    = (h + DIM_W'(ALIGN_MASK)) & ~DIM_W'(ALIGN_MASK);
  assign w_inc = w + DIM_W'(1);
  assign start = {w_inc[DIM_W-1:1], 1'b0};

  // plane products, one multiplier each
  always_ff @(posedge clk_i) begin
    uvbase_q <= UA_W'(pw) * UA_W'(ph);
    hpw_q    <= UA_W'(h) * UA_W'(pw);
    hhpw_q   <= UA_W'(h >> 1) * UA_W'(pw);
  end

  always_comb begin
    dims_o.w           = w;
    dims_o.h           = h;
    dims_o.pw          = pw;
    dims_o.ph          = ph;
    dims_o.fill_start  = start;
    dims_o.fill_uv_len = (pw > start) ? (pw - start) : '0;
    dims_o.margin      = pw > w;
    dims_o.uvbase      = uvbase_q;
    dims_o.hpw         = hpw_q;
    dims_o.hhpw        = hhpw_q;
  end

endmodule

// ----- hdl/bnp_front.sv -----
// front end: accepts pixels, tracks column and row, converts color, forms addresses
// depends on bnp_pkg
module bnp_front import bnp_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  pix_t  in_pix_i,
  input  dims_t dims_i,
  input  logic  q_full_i,
  output logic  push_o,
  output item_t item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [DIM_W-1:0] col_next, row_next;
  logic             row_end, frame_end, advance, accept;

  logic             s1_valid_q, s1_row_end_q, s1_frame_end_q;
  pix_t             s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;

  logic             s2_valid_q, s2_row_end_q, s2_frame_end_q, s2_even_q, s2_row_odd_q;
  logic [7:0]       s2_y_q, s2_u_q, s2_v_q;
  logic [CW-1:0]    s2_col_q;
  logic [UA_W-1:0]  s2_rowpw_q, s2_rowhpw_q;

  logic signed [17:0] rs, gs, bs, y_sum, u_sum, v_sum;
  logic [UA_W-1:0]    uv_row;

  function automatic logic [7:0] clamp8(input logic signed [17:0] v);
    if (v < 18'sd0) begin
      return 8'd0;
    end else if (v > 18'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  // pipeline moves unless the queue cannot take stage two
  assign advance    = !(s2_valid_q && q_full_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // row and frame end detection
  assign col_next  = DIM_W'(col_q) + DIM_W'(1);
  assign row_next  = DIM_W'(row_q) + DIM_W'(1);
  assign row_end   = col_next >= dims_i.w;
  assign frame_end = row_end && (row_next >= dims_i.h);

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_next[RW-1:0];
      end else begin
        col_q <= col_next[CW-1:0];
      end
    end
  end

  // stage one: capture pixel and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pix_q       <= in_pix_i;
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
      s1_row_end_q   <= row_end;
      s1_frame_end_q <= frame_end;
    end
  end

  // color sums
  assign rs    = $signed({10'b0, s1_pix_q.red});
  assign gs    = $signed({10'b0, s1_pix_q.green});
  assign bs    = $signed({10'b0, s1_pix_q.blue});
  assign y_sum = CY_R * rs + CY_G * gs + CY_B * bs + C_ROUND;
  assign u_sum = CU_R * rs + CU_G * gs + CU_B * bs + C_ROUND + C_UV_BIAS;
  assign v_sum = CV_R * rs + CV_G * gs + CV_B * bs + C_ROUND + C_UV_BIAS;

  // stage two: converted bytes and row products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_y_q         <= clamp8((y_sum >>> 8) + C_Y_OFS);
      s2_u_q         <= clamp8(u_sum >>> 8);
      s2_v_q         <= clamp8(v_sum >>> 8);
      s2_even_q      <= !(s1_row_q[0] | s1_col_q[0]);
      s2_row_odd_q   <= s1_row_q[0];
      s2_col_q       <= s1_col_q;
      s2_rowpw_q     <= UA_W'(s1_row_q) * UA_W'(dims_i.pw);
      s2_rowhpw_q    <= UA_W'(s1_row_q >> 1) * UA_W'(dims_i.pw);
      s2_row_end_q   <= s1_row_end_q;
      s2_frame_end_q <= s1_frame_end_q;
    end
  end

  // queue entry with final addresses
  assign uv_row = dims_i.uvbase + s2_rowhpw_q;
  assign push_o = advance && s2_valid_q;

  always_comb begin
    item_o.y_value      = s2_y_q;
    item_o.u_value      = s2_u_q;
    item_o.v_value      = s2_v_q;
    item_o.even         = s2_even_q;
    item_o.row_odd      = s2_row_odd_q;
    item_o.pix_y_addr   = YA_W'(s2_rowpw_q + UA_W'(s2_col_q));
    item_o.pix_uv_addr  = uv_row + UA_W'(s2_col_q);
    item_o.fill_y_addr  = YA_W'(s2_rowpw_q + UA_W'(dims_i.w));
    item_o.fill_uv_addr = uv_row + UA_W'(dims_i.fill_start);
    item_o.row_end      = s2_row_end_q;
    item_o.frame_end    = s2_frame_end_q;
  end

endmodule

// ----- hdl/bnp_queue.sv -----
// short fifo that decouples the front end from the result sequencer
// depends on bnp_pkg
module bnp_queue import bnp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t              store_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;
  logic               do_push, do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = store_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/bnp_back.sv -----
// back end: expands each queued pixel into its pixel write and fill runs
// depends on bnp_pkg
module bnp_back import bnp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t head_i,
  input  logic  q_empty_i,
  input  dims_t dims_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  out_res_o
);

  typedef enum logic [1:0] {
    PH_PIXEL,
    PH_RIGHT,
    PH_BOTTOM
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [DIM_W-1:0] j_q;
  logic [UA_W-1:0]  ybot_q, uvbot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  res_t             out_res_q;

  res_t             res;
  logic             load, nat_last, is_last, seed_bottom, step_bottom;
  logic             has_right, has_bottom;
  logic [DIM_W-1:0] j_inc;

  assign has_right  = head_i.row_end && dims_i.margin;
  assign has_bottom = head_i.frame_end && (dims_i.h < dims_i.ph);
  assign j_inc      = j_q + DIM_W'(1);
  assign load       = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign is_last    = nat_last || (cnt_q == CNT_W'(MAX_RESULTS - 1));
  assign pop_o      = load && is_last;

  // result for the current phase
  always_comb begin
    res         = '0;
    phase_d     = phase_q;
    nat_last    = 1'b1;
    seed_bottom = 1'b0;
    step_bottom = 1'b0;
    unique case (phase_q)
      PH_PIXEL: begin
        res.kind       = KIND_PIXEL;
        res.y_address  = head_i.pix_y_addr;
        res.y_value    = head_i.y_value;
        res.y_length   = LEN_W'(1);
        res.uv_write   = head_i.even;
        res.uv_address = head_i.pix_uv_addr;
        res.u_value    = head_i.u_value;
        res.v_value    = head_i.v_value;
        res.uv_length  = LEN_W'(2);
        nat_last       = !has_right && !has_bottom;
        seed_bottom    = !has_right && has_bottom;
        phase_d        = has_right ? PH_RIGHT : (has_bottom ? PH_BOTTOM : PH_PIXEL);
      end
      PH_RIGHT: begin
        res.kind       = KIND_FILL;
        res.y_address  = head_i.fill_y_addr;
        res.y_value    = Y_BLACK;
        res.y_length   = LEN_W'(dims_i.pw - dims_i.w);
        res.uv_write   = !head_i.row_odd && (dims_i.fill_uv_len != '0);
        res.uv_address = head_i.fill_uv_addr;
        res.u_value    = UV_GRAY;
        res.v_value    = UV_GRAY;
        res.uv_length  = LEN_W'(dims_i.fill_uv_len);
        nat_last       = !has_bottom;
        seed_bottom    = has_bottom;
        phase_d        = has_bottom ? PH_BOTTOM : PH_PIXEL;
      end
      PH_BOTTOM: begin
        res.kind       = KIND_FILL;
        res.y_address  = ybot_q[YA_W-1:0];
        res.y_value    = Y_BLACK;
        res.y_length   = LEN_W'(dims_i.pw);
        res.uv_write   = !j_q[0];
        res.uv_address = uvbot_q;
        res.u_value    = UV_GRAY;
        res.v_value    = UV_GRAY;
        res.uv_length  = LEN_W'(dims_i.pw);
        nat_last       = j_inc == dims_i.ph;
        step_bottom    = 1'b1;
        phase_d        = PH_BOTTOM;
      end
      default: begin
        phase_d = PH_PIXEL;
      end
    endcase
    // chroma fields read zero when no chroma is written
    if (!res.uv_write) begin
      res.uv_address = '0;
      res.u_value    = '0;
      res.v_value    = '0;
      res.uv_length  = '0;
    end
    res.last = is_last;
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PIXEL;
      cnt_q       <= '0;
      j_q         <= '0;
      ybot_q      <= '0;
      uvbot_q     <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res;
        if (is_last) begin
          phase_q <= PH_PIXEL;
          cnt_q   <= '0;
        end else begin
          phase_q <= phase_d;
          cnt_q   <= cnt_q + 1'b1;
        end
        if (seed_bottom) begin
          j_q     <= dims_i.h;
          ybot_q  <= dims_i.hpw;
          uvbot_q <= dims_i.uvbase + dims_i.hhpw;
        end else if (step_bottom) begin
          j_q    <= j_inc;
          ybot_q <= ybot_q + UA_W'(dims_i.pw);
          if (j_q[0]) begin
            uvbot_q <= uvbot_q + UA_W'(dims_i.pw);
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- hdl/bnp_checker.sv -----
// port level checks for the converter, bound to the top level
// depends on bnp_pkg and bgra_to_nv12_padded_converter_top
module bnp_checker import bnp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_res_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("result changed while stalled");

  // a transaction that is not the last of its pixel is followed at once by a fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_res_o.last
      |=> out_valid_o && out_res_o.kind == KIND_FILL)
    else $error("fill result missing after non-final result");

  // input stall only with a full queue, so a result follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("input stalled while output idle");

endmodule

bind bgra_to_nv12_padded_converter_top bnp_checker u_bnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
